// File: design/vsf_pkg.sv
`default_nettype none

package vsf_pkg;

    localparam int unsigned LEN_BITS = 20;

    typedef enum logic
    {
        REG_MIN_VOICED = 1'b0,
        REG_MAX_GAP    = 1'b1
    } vsf_reg_t;

    typedef struct packed
    {
        logic [LEN_BITS-1:0] min_voiced_length;
        logic [LEN_BITS-1:0] max_gap_length;
    } vsf_cfg_t;

    typedef struct packed
    {
        logic                emit;
        logic [LEN_BITS-1:0] start_idx;
        logic [LEN_BITS-1:0] end_idx;
    } vsf_result_t;

endpackage

`default_nettype wire

// File: design/voiced_segment_finder.sv
`default_nettype none

// Finds voiced segments in a pitch track delivered one sample per transfer.
// Input channel: pitch_value and last_sample, with in_valid and in_ready.
// Output channel: segment_start and segment_end, with out_valid and out_ready.
// Each input transfer yields at most one segment, which appears on the output
// register in the cycle after the transfer that closed it.
// One sample is taken every cycle; the only limit is the single output
// register, so in_ready drops only while a segment waits and out_ready is low.
// A stalled receiver therefore holds back the input channel, and no segment
// is lost or repeated.
// The two length registers are written through the APB port at byte address
// 0 (minimum voiced length) and 4 (maximum gap length), and read back there.
// Reset clears the tracking state, out_valid and both registers; segment_start and segment_end are not reset.
// After a sample marked last_sample the tracking state returns to its reset
// value and the next sample has index zero; the registers are kept.
module voiced_segment_finder #(
    parameter int unsigned INDEX_BITS = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] pitch_value,
    input  wire logic        last_sample,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [19:0]      segment_start,
    output logic [19:0]      segment_end
);
    import vsf_pkg::*;

    vsf_cfg_t    cfg_reg;
    vsf_result_t result;
    vsf_reg_t    reg_sel;
    logic        in_xfer;
    logic        cfg_write;
    logic        out_valid_reg;
    logic [LEN_BITS-1:0] start_reg;
    logic [LEN_BITS-1:0] end_reg;

    assign pready    = 1'b1;
    assign reg_sel   = vsf_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;

    always_comb
    begin
        unique case (reg_sel)
            REG_MIN_VOICED: prdata = 32'(cfg_reg.min_voiced_length);
            REG_MAX_GAP:    prdata = 32'(cfg_reg.max_gap_length);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_MIN_VOICED: cfg_reg.min_voiced_length <= pwdata[LEN_BITS-1:0];
                REG_MAX_GAP:    cfg_reg.max_gap_length    <= pwdata[LEN_BITS-1:0];
                default:        ;
            endcase
        end
    end

    vsf_tracker #(
        .INDEX_BITS (INDEX_BITS)
    ) u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_xfer),
        .voiced (pitch_value != 16'd0),
        .last   (last_sample),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer && result.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && result.emit)
        begin
            start_reg <= result.start_idx;
            end_reg   <= result.end_idx;
        end
    end

    assign out_valid     = out_valid_reg;
    assign segment_start = start_reg;
    assign segment_end   = end_reg;

endmodule

`default_nettype wire

// File: design/vsf_tracker.sv
`default_nettype none

module vsf_tracker #(
    parameter int unsigned INDEX_BITS = 20
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              voiced,
    input  wire logic              last,
    input  vsf_pkg::vsf_cfg_t      cfg,
    output vsf_pkg::vsf_result_t   result
);
    import vsf_pkg::*;

    localparam int unsigned OUT_W = (INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS;
    localparam int unsigned CMP_W = OUT_W + 1;
    localparam logic [INDEX_BITS-1:0] POS_MAX = {INDEX_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]   GAP_MAX = {LEN_BITS{1'b1}};

    logic [INDEX_BITS-1:0] pos_reg;
    logic [INDEX_BITS-1:0] pos_next;
    logic [INDEX_BITS-1:0] seg_start_reg;
    logic [INDEX_BITS-1:0] seg_start_next;
    logic [INDEX_BITS-1:0] gap_start_reg;
    logic [INDEX_BITS-1:0] gap_start_next;
    logic [LEN_BITS-1:0]   gap_len_reg;
    logic [LEN_BITS-1:0]   gap_len_next;
    logic                  open_reg;
    logic                  open_next;

    logic [LEN_BITS-1:0]   gap_len_inc;
    logic [INDEX_BITS-1:0] gap_start_cur;
    logic [INDEX_BITS:0]   len_voiced;
    logic [INDEX_BITS:0]   len_gap;
    logic [INDEX_BITS-1:0] end_gap;
    logic [INDEX_BITS:0]   seg_len;
    logic [INDEX_BITS-1:0] seg_end;
    logic                  closing;
    logic [OUT_W-1:0]      start_ext;
    logic [OUT_W-1:0]      end_ext;

    always_comb
    begin
        gap_len_inc   = (gap_len_reg < GAP_MAX) ? gap_len_reg + 1'b1 : gap_len_reg;
        gap_start_cur = (gap_len_reg == '0) ? pos_reg : gap_start_reg;
        len_voiced    = {1'b0, pos_reg} - {1'b0, seg_start_reg} + 1'b1;
        len_gap       = {1'b0, gap_start_cur} - {1'b0, seg_start_reg};
        end_gap       = (gap_start_cur > seg_start_reg) ? gap_start_cur - 1'b1
                                                        : seg_start_reg;

        pos_next       = pos_reg;
        seg_start_next = seg_start_reg;
        gap_start_next = gap_start_reg;
        gap_len_next   = gap_len_reg;
        open_next      = open_reg;
        closing        = 1'b0;
        seg_len        = len_gap;
        seg_end        = end_gap;

        if (voiced)
        begin
            if (!open_reg)
            begin
                seg_start_next = pos_reg;
                open_next      = 1'b1;
            end
            gap_len_next = '0;
            if (last)
            begin
                closing = 1'b1;
                seg_len = open_reg ? len_voiced : {{INDEX_BITS{1'b0}}, 1'b1};
                seg_end = pos_reg;
            end
        end
        else if (open_reg)
        begin
            gap_start_next = gap_start_cur;
            gap_len_next   = gap_len_inc;
            if (last || (gap_len_inc > cfg.max_gap_length))
            begin
                closing = 1'b1;
            end
        end

        if (closing)
        begin
            open_next    = 1'b0;
            gap_len_next = '0;
        end

        if (last)
        begin
            pos_next       = '0;
            seg_start_next = '0;
            gap_start_next = '0;
            gap_len_next   = '0;
            open_next      = 1'b0;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end

        start_ext = OUT_W'(open_reg ? seg_start_reg : pos_reg);
        end_ext   = OUT_W'(seg_end);

        result.emit      = closing
                           && (CMP_W'(seg_len) > CMP_W'(cfg.min_voiced_length));
        result.start_idx = start_ext[LEN_BITS-1:0];
        result.end_idx   = end_ext[LEN_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            seg_start_reg <= '0;
            gap_start_reg <= '0;
            gap_len_reg   <= '0;
            open_reg      <= 1'b0;
        end
        else if (step)
        begin
            pos_reg       <= pos_next;
            seg_start_reg <= seg_start_next;
            gap_start_reg <= gap_start_next;
            gap_len_reg   <= gap_len_next;
            open_reg      <= open_next;
        end
    end

endmodule

`default_nettype wire
